>>> rtl/midi_enc_pkg.sv
// Types and constants shared by the MIDI track event encoder.
package midi_enc_pkg;

    typedef enum logic [1:0] {
        REQ_CHAN  = 2'd0,
        REQ_META  = 2'd1,
        REQ_EOT   = 2'd2,
        REQ_START = 2'd3
    } t_req;

    localparam int unsigned MAX_BYTES = 10;
    localparam int unsigned VLQ_GROUPS = 5;

    localparam logic [7:0] BYTE_META   = 8'hff;
    localparam logic [7:0] BYTE_EOT    = 8'h2f;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_CONT   = 8'h80;
    localparam logic [7:0] CHAR_M      = 8'h4d;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_K      = 8'h6b;

    localparam logic [6:0] META_SEQ_NUM   = 7'h00;
    localparam logic [6:0] META_KEY_SIG   = 7'h59;
    localparam logic [6:0] META_CHAN_PFX  = 7'h20;
    localparam logic [6:0] META_PORT      = 7'h21;

    typedef logic [7:0] t_burst [0:MAX_BYTES-1];

endpackage

>>> rtl/midi_track_event_encoder_top.sv
// MIDI track event encoder: requests in, Standard MIDI File track bytes out.
//
//  channel   | dir | tdata (low bit up)                                  | tlast | tuser
//  ----------+-----+-----------------------------------------------------+-------+-------------
//  s_axis    | in  | event_time, status_byte, data_one, data_two,        |  -    | req_type
//            |     | msg_len, meta_kind, header_length, pad (104 bits)   |       |
//  m_axis    | out | out_byte, track_bytes (40 bits)                     | last  | late_event
//
//  A request is held in an input register and expanded combinationally into a burst of up to ten
//  bytes; the burst register then shifts out one byte per cycle while m_axis_tready is high. A
//  request produces at most ten bytes; one that produces none is still taken from the input register.
//  The next request is taken while the final byte of a burst is delivered.
//  i_rst_n is synchronous, active low; it clears the track state and both valid flags.
//  m_axis_tready low holds the current byte and, once the input register is full, stalls s_axis.
module midi_track_event_encoder_top
    import midi_enc_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // event_time[31:0], status_byte[39:32], data_one[47:40], data_two[55:48],
    // msg_len[57:56], meta_kind[64:58], header_length[96:65], zero pad[103:97]
    input  logic [103:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_byte[7:0], track_bytes[39:8]
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // late_event[0]
    output logic         m_axis_tuser
);

    // input register
    logic                 r_in_valid;
    logic [1:0]           r_req;
    logic [31:0]          r_time;
    logic [7:0]           r_status;
    logic [7:0]           r_d1;
    logic [7:0]           r_d2;
    logic [1:0]           r_len;
    logic [6:0]           r_kind;
    logic [31:0]          r_hlen;

    // track state
    logic [TIME_BITS-1:0] r_last_time, n_last_time;
    logic [7:0]           r_run, n_run;
    logic                 r_in_track, n_in_track;
    logic [31:0]          r_body_count, n_body_count;

    // burst register
    t_burst               r_bytes;
    logic [3:0]           r_left;
    logic [31:0]          r_cnt;
    logic                 r_late;
    logic                 r_body;

    t_burst               c_bytes;
    logic [3:0]           c_n;
    logic                 c_late;
    logic                 c_body;
    logic [TIME_BITS-1:0] now_raw;
    logic [TIME_BITS-1:0] now_sel;
    logic [31:0]          delta;
    logic [6:0]           grp [0:VLQ_GROUPS-1];
    logic [2:0]           vlq_n;
    logic [1:0]           meta_len;
    t_req                 req;

    logic burst_free, load_fire, out_fire, in_fire;

    assign out_fire   = (r_left != 4'd0) && m_axis_tready;
    assign burst_free = (r_left == 4'd0) || ((r_left == 4'd1) && m_axis_tready);
    assign load_fire  = r_in_valid && burst_free;
    assign s_axis_tready = !r_in_valid || load_fire;
    assign in_fire    = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_left != 4'd0);
    assign m_axis_tdata  = {r_cnt, r_bytes[0]};
    assign m_axis_tlast  = (r_left == 4'd1);
    assign m_axis_tuser  = r_late;

    assign req     = t_req'(r_req);
    assign now_raw = r_time[TIME_BITS-1:0];
    assign now_sel = ((req == REQ_EOT) && (now_raw == '0)) ? r_last_time : now_raw;
    assign delta   = (now_sel < r_last_time) ? 32'd0 : 32'(now_sel - r_last_time);

    assign grp[0] = delta[6:0];
    assign grp[1] = delta[13:7];
    assign grp[2] = delta[20:14];
    assign grp[3] = delta[27:21];
    assign grp[4] = {3'd0, delta[31:28]};

    always_comb begin
        priority if (delta[31:28] != 4'd0) vlq_n = 3'd5;
        else if (delta[27:21] != 7'd0)     vlq_n = 3'd4;
        else if (delta[20:14] != 7'd0)     vlq_n = 3'd3;
        else if (delta[13:7] != 7'd0)      vlq_n = 3'd2;
        else                               vlq_n = 3'd1;
    end

    always_comb begin
        if ((r_kind == META_SEQ_NUM) || (r_kind == META_KEY_SIG))      meta_len = 2'd2;
        else if ((r_kind == META_CHAN_PFX) || (r_kind == META_PORT))   meta_len = 2'd1;
        else                                                           meta_len = 2'd0;
    end

    always_comb begin
        c_bytes      = '{default: 8'd0};
        c_n          = 4'd0;
        c_late       = (now_sel < r_last_time);
        c_body       = 1'b1;
        n_last_time  = r_last_time;
        n_run        = r_run;
        n_in_track   = r_in_track;
        n_body_count = r_body_count;

        // delta time, most significant group first
        for (int k = 0; k < VLQ_GROUPS; k++) begin
            if (3'(k) < vlq_n) begin
                c_bytes[k] = {(3'(k) != (vlq_n - 3'd1)), grp[3'(vlq_n - 3'(k) - 3'd1)]};
            end
        end

        unique case (req)
            REQ_CHAN: begin
                if (r_len != 2'd0) begin
                    c_n = {1'b0, vlq_n};
                    if (r_status != r_run) begin
                        c_bytes[c_n] = r_status;
                        c_n          = c_n + 4'd1;
                        n_run        = r_status;
                    end
                    if (r_len > 2'd1) begin
                        c_bytes[c_n] = r_d1;
                        c_n          = c_n + 4'd1;
                    end
                    if (r_len > 2'd2) begin
                        c_bytes[c_n] = r_d2;
                        c_n          = c_n + 4'd1;
                    end
                    n_last_time = now_sel;
                end
            end
            REQ_META: begin
                c_n          = {1'b0, vlq_n};
                c_bytes[c_n] = BYTE_META;
                c_n          = c_n + 4'd1;
                c_bytes[c_n] = {1'b0, r_kind};
                c_n          = c_n + 4'd1;
                c_bytes[c_n] = {6'd0, meta_len};
                c_n          = c_n + 4'd1;
                if (meta_len > 2'd0) begin
                    c_bytes[c_n] = r_d1;
                    c_n          = c_n + 4'd1;
                end
                if (meta_len > 2'd1) begin
                    c_bytes[c_n] = r_d2;
                    c_n          = c_n + 4'd1;
                end
                n_last_time = now_sel;
                n_run       = 8'd0;
            end
            REQ_EOT: begin
                if (r_in_track) begin
                    c_n          = {1'b0, vlq_n};
                    c_bytes[c_n] = BYTE_META;
                    c_n          = c_n + 4'd1;
                    c_bytes[c_n] = BYTE_EOT;
                    c_n          = c_n + 4'd1;
                    c_bytes[c_n] = BYTE_ZERO;
                    c_n          = c_n + 4'd1;
                    n_last_time  = now_sel;
                    n_run        = 8'd0;
                    n_in_track   = 1'b0;
                end
            end
            REQ_START: begin
                c_late      = 1'b0;
                c_body      = 1'b0;
                c_bytes     = '{CHAR_M, CHAR_T, CHAR_R, CHAR_K,
                                r_hlen[31:24], r_hlen[23:16], r_hlen[15:8], r_hlen[7:0],
                                BYTE_ZERO, BYTE_ZERO};
                c_n         = 4'd8;
                n_last_time = '0;
                n_run       = 8'd0;
                n_in_track  = 1'b1;
            end
            default: begin
                c_n = 4'd0;
            end
        endcase

        if (c_body) begin
            n_body_count = r_body_count + {28'd0, c_n};
        end else begin
            n_body_count = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req    <= s_axis_tuser;
            r_time   <= s_axis_tdata[31:0];
            r_status <= s_axis_tdata[39:32];
            r_d1     <= s_axis_tdata[47:40];
            r_d2     <= s_axis_tdata[55:48];
            r_len    <= s_axis_tdata[57:56];
            r_kind   <= s_axis_tdata[64:58];
            r_hlen   <= s_axis_tdata[96:65];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_run        <= 8'd0;
            r_in_track   <= 1'b0;
            r_body_count <= 32'd0;
        end else if (load_fire) begin
            r_last_time  <= n_last_time;
            r_run        <= n_run;
            r_in_track   <= n_in_track;
            r_body_count <= n_body_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
        end else if (load_fire && (c_n != 4'd0)) begin
            r_left <= c_n;
        end else if (out_fire) begin
            r_left <= r_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_fire && (c_n != 4'd0)) begin
            r_bytes <= c_bytes;
            r_late  <= c_late;
            r_body  <= c_body;
            r_cnt   <= c_body ? (r_body_count + 32'd1) : 32'd0;
        end else if (out_fire) begin
            for (int k = 0; k < MAX_BYTES - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
            r_bytes[MAX_BYTES-1] <= 8'd0;
            if (r_body) begin
                r_cnt <= r_cnt + 32'd1;
            end
        end
    end

endmodule
